// ===== hdl/datm_pkg.sv =====
// Shared types and constants for the DMA address translation map.
// No dependencies; every other file but datm_ram refers to it by scoped names.
package datm_pkg;

	localparam int unsigned PAGE_SHIFT = 10;
	localparam int unsigned PHYS_W     = 26;
	localparam int unsigned PAGE_W     = 16;
	localparam int unsigned COUNT_W    = 9;
	localparam int unsigned ADDR_W     = 32;
	// index width covering every supported table size and entry count
	localparam int unsigned IDX_W      = 11;
	localparam int unsigned RAW_W      = 7;
	localparam int unsigned REACH_BYTE = 64;
	localparam int unsigned REACH_WORD = 128;
	localparam int unsigned IN_DATA_W  = 48;
	localparam int unsigned IN_USER_W  = 3;
	localparam int unsigned OUT_DATA_W = 48;

	typedef enum logic [1:0] {
		MODE_READ      = 2'd0,
		MODE_WRITE     = 2'd1,
		MODE_TRANSLATE = 2'd2
	} mode_t;

	typedef enum logic {
		ST_CLEAR = 1'b0,
		ST_RUN   = 1'b1
	} state_t;

	// table lookup request produced by the address decoder
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             oob;
		logic             hit;
		logic             region;
	} req_t;

endpackage

// ===== hdl/datm_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module datm_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/datm_decode.sv =====
// Address decoder: table index for programmed and translate accesses, plus
// the entry-hit and region flags. Depends on datm_pkg.
module datm_decode #(
	parameter int unsigned DEFAULT_ENTRIES = 128,
	parameter int unsigned MAX_ENTRIES     = 256,
	parameter int unsigned WINDOW_FIRST    = 0,
	parameter int unsigned MAP_BASE        = 0,
	parameter int unsigned MAP_LIMIT       = 255
) (
	input  datm_pkg::mode_t                   mode,
	input  logic [datm_pkg::ADDR_W-1:0]       address,
	input  logic                              word_transfer,
	input  logic [datm_pkg::COUNT_W-1:0]      entry_count,
	output datm_pkg::req_t                    req
);

	localparam logic [datm_pkg::ADDR_W-1:0] BASE  = datm_pkg::ADDR_W'(MAP_BASE);
	localparam logic [datm_pkg::ADDR_W-1:0] LIMIT = datm_pkg::ADDR_W'(MAP_LIMIT);
	localparam logic [datm_pkg::IDX_W-1:0] DEF_MASK =
		datm_pkg::IDX_W'(DEFAULT_ENTRIES - 1);
	localparam logic [datm_pkg::IDX_W-1:0] WIN = datm_pkg::IDX_W'(WINDOW_FIRST);
	localparam logic [datm_pkg::RAW_W-1:0] MASK_BYTE =
		datm_pkg::RAW_W'(datm_pkg::REACH_BYTE - 1);
	localparam logic [datm_pkg::RAW_W-1:0] MASK_WORD =
		datm_pkg::RAW_W'(datm_pkg::REACH_WORD - 1);

	logic [datm_pkg::ADDR_W-1:0] off;
	logic [datm_pkg::IDX_W-1:0]  n;
	logic [datm_pkg::IDX_W-1:0]  pidx;
	logic [datm_pkg::RAW_W-1:0]  raw;
	logic [datm_pkg::IDX_W-1:0]  tidx;
	logic [datm_pkg::ADDR_W-1:0] span;
	logic                        above_base;

	always_comb begin
		off  = address - BASE;
		n    = (entry_count == '0) ? datm_pkg::IDX_W'(DEFAULT_ENTRIES)
		                           : datm_pkg::IDX_W'(entry_count);
		pidx = off[datm_pkg::IDX_W:1] & (n - datm_pkg::IDX_W'(1));

		raw  = address[datm_pkg::PAGE_SHIFT +: datm_pkg::RAW_W] &
		       (word_transfer ? MASK_WORD : MASK_BYTE);
		tidx = (WIN + datm_pkg::IDX_W'(raw)) & DEF_MASK;

		req.idx = (mode == datm_pkg::MODE_TRANSLATE) ? tidx : pidx;
		req.oob = (32'(req.idx) >= MAX_ENTRIES);

		// stored count taken as it is: a count of zero never hits
		span       = datm_pkg::ADDR_W'({entry_count, 1'b0});
		above_base = (address >= BASE);
		req.hit    = above_base && (off < span);
		req.region = above_base && (address <= LIMIT);
	end

endmodule

// ===== hdl/dma_address_translation_map.sv =====
// DMA address translation map: page table with programmed access and DMA translate.
// An accepted s_ transaction passes the table read stage and the output register
// on its way to m_tvalid; one transaction per cycle sustained while m_tready is
// high, set by the single RAM port shared by reads and writes. Reset: entry_count
// returns to DEFAULT_ENTRIES, then a clearing pass zeroes the table with s_tready
// low (cfg writes still taken). Depends on datm_pkg, datm_decode and datm_ram.
module dma_address_translation_map #(
	parameter int unsigned DEFAULT_ENTRIES = 128,
	parameter int unsigned MAX_ENTRIES     = 256,
	parameter int unsigned WINDOW_FIRST    = 0,
	parameter int unsigned MAP_BASE        = 0,
	parameter int unsigned MAP_LIMIT       = 255
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [31:0] address, [47:32] write_value
	input  logic [datm_pkg::IN_DATA_W-1:0]     s_tdata,
	// [1:0] mode, [2] word_transfer
	input  logic [datm_pkg::IN_USER_W-1:0]     s_tuser,
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [15:0] read_data, [41:16] physical_address, [42] hits_entry,
	// [43] within_region, [47:44] zero
	output logic [datm_pkg::OUT_DATA_W-1:0]    m_tdata,
	// entry_count register write
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [datm_pkg::COUNT_W-1:0]       cfg_data
);

	localparam int unsigned AW = $clog2(MAX_ENTRIES);
	localparam logic [AW-1:0] CLR_LAST = AW'(MAX_ENTRIES - 1);

	// unpack the input transaction
	datm_pkg::mode_t                    in_mode;
	logic [datm_pkg::ADDR_W-1:0]        in_address;
	logic                               in_word;
	logic [datm_pkg::PAGE_W-1:0]        in_write_value;
	logic [datm_pkg::PAGE_SHIFT-1:0]    in_offset;

	assign in_mode        = datm_pkg::mode_t'(s_tuser[1:0]);
	assign in_word        = s_tuser[2];
	assign in_address     = s_tdata[31:0];
	assign in_write_value = s_tdata[47:32];
	// 16-bit transfers drop the byte-select bit of the page offset
	assign in_offset      = in_word ? {in_address[datm_pkg::PAGE_SHIFT-1:1], 1'b0}
	                                : in_address[datm_pkg::PAGE_SHIFT-1:0];

	// entry count register, saturating at the table size
	logic [datm_pkg::COUNT_W-1:0] count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= datm_pkg::COUNT_W'(DEFAULT_ENTRIES);
		end else if (cfg_valid && cfg_ready) begin
			count_q <= (32'(cfg_data) > MAX_ENTRIES) ? datm_pkg::COUNT_W'(MAX_ENTRIES)
			                                       : cfg_data;
		end
	end

	// decode the incoming address
	datm_pkg::req_t req;

	datm_decode #(
		.DEFAULT_ENTRIES (DEFAULT_ENTRIES),
		.MAX_ENTRIES     (MAX_ENTRIES),
		.WINDOW_FIRST    (WINDOW_FIRST),
		.MAP_BASE        (MAP_BASE),
		.MAP_LIMIT       (MAP_LIMIT)
	) u_decode (
		.mode          (in_mode),
		.address       (in_address),
		.word_transfer (in_word),
		.entry_count   (count_q),
		.req           (req)
	);

	// clearing pass after reset
	datm_pkg::state_t state_q, state_d;
	logic [AW-1:0]    clr_q;
	logic             clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= datm_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		clearing = 1'b0;
		unique case (state_q)
			datm_pkg::ST_CLEAR: begin
				clearing = 1'b1;
				if (clr_q == CLR_LAST) begin
					state_d = datm_pkg::ST_RUN;
				end
			end
			datm_pkg::ST_RUN: begin
				state_d = datm_pkg::ST_RUN;
			end
			default: begin
				state_d = datm_pkg::ST_CLEAR;
			end
		endcase
	end

	// pipeline handshake: s1 holds the table read, s2 is the output register
	logic valid_s1, valid_s2;
	logic out_load, accept;

	assign out_load = !valid_s2 || m_tready;
	assign s_tready = (state_q == datm_pkg::ST_RUN) && (!valid_s1 || out_load);
	assign accept   = s_tvalid && s_tready;

	// page table: one access per cycle, read data lands with stage 1
	logic                        ram_en, ram_we;
	logic [AW-1:0]               ram_addr;
	logic [datm_pkg::PAGE_W-1:0] ram_wdata, ram_rdata;

	always_comb begin
		ram_en    = clearing || accept;
		ram_we    = clearing || (accept && in_mode == datm_pkg::MODE_WRITE && !req.oob);
		ram_addr  = clearing ? clr_q : req.idx[AW-1:0];
		ram_wdata = clearing ? '0 : in_write_value;
	end

	datm_ram #(
		.WIDTH (datm_pkg::PAGE_W),
		.DEPTH (MAX_ENTRIES)
	) u_table (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// stage 1: hold the transaction alongside the RAM read
	datm_pkg::mode_t                 mode_s1;
	logic [datm_pkg::PAGE_SHIFT-1:0] offset_s1;
	logic                            oob_s1, hit_s1, region_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1   <= in_mode;
			offset_s1 <= in_offset;
			oob_s1    <= req.oob;
			hit_s1    <= req.hit;
			region_s1 <= req.region;
		end
	end

	// form the result: entries beyond storage read as zero
	logic [datm_pkg::PAGE_W-1:0] page_s1;
	logic [datm_pkg::PAGE_W-1:0] rd_d;
	logic [datm_pkg::PHYS_W-1:0] pa_d;

	always_comb begin
		page_s1 = oob_s1 ? '0 : ram_rdata;
		rd_d    = '0;
		pa_d    = '0;
		unique case (mode_s1)
			datm_pkg::MODE_READ:      rd_d = page_s1;
			datm_pkg::MODE_WRITE:     rd_d = '0;
			datm_pkg::MODE_TRANSLATE: pa_d = datm_pkg::PHYS_W'({page_s1, offset_s1});
			default:                  rd_d = '0;
		endcase
	end

	// stage 2: output register, advance when empty or taken
	logic [datm_pkg::PAGE_W-1:0] rd_s2;
	logic [datm_pkg::PHYS_W-1:0] pa_s2;
	logic                        hit_s2, region_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && valid_s1) begin
			rd_s2     <= rd_d;
			pa_s2     <= pa_d;
			hit_s2    <= hit_s1;
			region_s2 <= region_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0000, region_s2, hit_s2, pa_s2, rd_s2};

endmodule

// ===== test/datm_checker.sv =====
`timescale 1ns / 100ps
// Checker for the DMA address translation map: watches the input, result and
// count-register channels, predicts every result and compares it field by field.
// Depends on datm_pkg for widths and access modes.
module datm_checker #(
	parameter int unsigned DEFAULT_ENTRIES = 128,
	parameter int unsigned MAX_ENTRIES     = 256,
	parameter int unsigned WINDOW_FIRST    = 0,
	parameter int unsigned MAP_BASE        = 0,
	parameter int unsigned MAP_LIMIT       = 255
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	// [31:0] address, [47:32] write_value
	input  logic [datm_pkg::IN_DATA_W-1:0]  s_tdata,
	// [1:0] mode, [2] word_transfer
	input  logic [datm_pkg::IN_USER_W-1:0]  s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// [15:0] read_data, [41:16] physical_address, [42] hits_entry, [43] within_region
	input  logic [datm_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [datm_pkg::COUNT_W-1:0]    cfg_data,
	output int                              mismatches,
	output int                              outstanding
);

	localparam int unsigned SW = $clog2(MAX_ENTRIES);

	// packed so that read_data sits in the lowest bits, as on m_tdata
	typedef struct packed {
		logic                              within_region;
		logic                              hits_entry;
		logic [datm_pkg::PHYS_W-1:0]       phys_addr;
		logic [datm_pkg::PAGE_W-1:0]       read_data;
	} map_result_t;

	logic [datm_pkg::PAGE_W-1:0] page_shadow [MAX_ENTRIES];
	logic [31:0]                 count_shadow;
	map_result_t                 expected_q [$];
	int                          err_count;

	function automatic logic [31:0] program_slot(input logic [31:0] addr);
		logic [31:0] span;
		span = (count_shadow == 0) ? DEFAULT_ENTRIES : count_shadow;
		return ((addr - MAP_BASE) >> 1) & (span - 1);
	endfunction

	// Apply one access to the shadow table and return the result it produces.
	function automatic map_result_t apply_access(input logic [1:0] mode,
			input logic [31:0] addr, input logic word, input logic [15:0] value);
		map_result_t res;
		logic [31:0] slot;
		logic [31:0] reach;
		logic [31:0] offset;
		logic [31:0] page;
		res = '0;
		if (mode == datm_pkg::MODE_READ) begin
			slot = program_slot(addr);
			if (slot < MAX_ENTRIES)
				res.read_data = page_shadow[slot[SW-1:0]];
		end else if (mode == datm_pkg::MODE_WRITE) begin
			slot = program_slot(addr);
			if (slot < MAX_ENTRIES)
				page_shadow[slot[SW-1:0]] = value;
		end else if (mode == datm_pkg::MODE_TRANSLATE) begin
			reach  = word ? datm_pkg::REACH_WORD : datm_pkg::REACH_BYTE;
			slot   = (WINDOW_FIRST + ((addr >> datm_pkg::PAGE_SHIFT) & (reach - 1)))
				& (DEFAULT_ENTRIES - 1);
			offset = addr & ((32'd1 << datm_pkg::PAGE_SHIFT) - (word ? 32'd2 : 32'd1));
			page   = (slot < MAX_ENTRIES) ?
				({16'd0, page_shadow[slot[SW-1:0]]} << datm_pkg::PAGE_SHIFT) : 32'd0;
			res.phys_addr = page[datm_pkg::PHYS_W-1:0] | offset[datm_pkg::PHYS_W-1:0];
		end
		res.hits_entry    = (addr >= MAP_BASE) && ((addr - MAP_BASE) < count_shadow * 2);
		res.within_region = (addr >= MAP_BASE) && (addr <= MAP_LIMIT);
		return res;
	endfunction

	task automatic check_field(input string label, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, label, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		map_result_t got;
		map_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_ENTRIES; i++)
				page_shadow[i] = '0;
			count_shadow = DEFAULT_ENTRIES;
			expected_q.delete();
			err_count = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// results leave only after registered stages, so compare before queuing
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(map_result_t)-1:0];
				if (expected_q.size() == 0) begin
					$display("%0t: result with no access pending, expected none, got %h",
						$time, m_tdata);
					err_count++;
				end else begin
					want = expected_q.pop_front();
					check_field("read_data", 32'(want.read_data), 32'(got.read_data));
					check_field("physical_address", 32'(want.phys_addr),
						32'(got.phys_addr));
					check_field("hits_entry", 32'(want.hits_entry), 32'(got.hits_entry));
					check_field("within_region", 32'(want.within_region),
						32'(got.within_region));
				end
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(apply_access(s_tuser[1:0], s_tdata[31:0],
					s_tuser[2], s_tdata[47:32]));
			if (cfg_valid && cfg_ready)
				count_shadow = (cfg_data > MAX_ENTRIES) ? MAX_ENTRIES : cfg_data;
			mismatches  <= err_count;
			outstanding <= expected_q.size();
		end
	end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Top of the testbench for dma_address_translation_map: clock, reset, stimulus,
// result-side flow control and the verdict. Depends on datm_pkg, datm_checker and dma_address_translation_map.
module tb;

	localparam int unsigned DEFAULT_ENTRIES = 128;
	localparam int unsigned MAX_ENTRIES     = 256;
	localparam int unsigned WINDOW_FIRST    = 0;
	localparam int unsigned MAP_BASE        = 0;
	localparam int unsigned MAP_LIMIT       = 255;

	// the fourth mode code is unused by the block
	localparam logic [1:0] MODE_SPARE   = 2'd3;
	localparam int         HOLD_CYCLES  = 300;
	localparam int         PHASE_ITEMS  = 82;
	localparam int         PHASES       = 9;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	// [31:0] address, [47:32] write_value
	logic [datm_pkg::IN_DATA_W-1:0]  s_tdata;
	// [1:0] mode, [2] word_transfer
	logic [datm_pkg::IN_USER_W-1:0]  s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	// [15:0] read_data, [41:16] physical_address, [42] hits_entry, [43] within_region
	logic [datm_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [datm_pkg::COUNT_W-1:0]    cfg_data;

	int mismatches;
	int outstanding;

	// stimulus knobs shared with the result-side process
	bit idle_enabled = 1'b1;
	int backpressure_req = 0;
	int backpressure_done = 0;

	dma_address_translation_map #(
		.DEFAULT_ENTRIES(DEFAULT_ENTRIES),
		.MAX_ENTRIES    (MAX_ENTRIES),
		.WINDOW_FIRST   (WINDOW_FIRST),
		.MAP_BASE       (MAP_BASE),
		.MAP_LIMIT      (MAP_LIMIT)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	datm_checker #(
		.DEFAULT_ENTRIES(DEFAULT_ENTRIES),
		.MAX_ENTRIES    (MAX_ENTRIES),
		.WINDOW_FIRST   (WINDOW_FIRST),
		.MAP_BASE       (MAP_BASE),
		.MAP_LIMIT      (MAP_LIMIT)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Drive m_tready at every falling edge. On request, hold it low for a long
	// stretch so the block fills up and pushes back on its input.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (backpressure_req != backpressure_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				backpressure_done++;
			end
			m_tready <= !(idle_enabled && $urandom_range(99) < 11);
		end
	end

	// Abort a hung run; a correct run needs only a small fraction of this.
	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Offer one access and hold it until the block takes the transaction.
	// Idle gaps of random length go in front of the item.
	task automatic push_access(input logic [1:0] mode, input logic [31:0] addr,
			input logic word, input logic [15:0] value);
		@(negedge clk);
		while (idle_enabled && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {value, addr};
		s_tuser  <= {word, mode};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Drop s_tvalid and wait until every expected result has come back.
	task automatic drain;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_count(input logic [datm_pkg::COUNT_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly table reads and writes in and just past the configured span, plus translates
	// with random addresses; the rest is the spare mode and stray addresses.
	task automatic random_phase(input int items, input int unsigned count_reg);
		int unsigned span;
		int unsigned pick;
		logic [31:0] addr;
		span = (count_reg == 0) ? DEFAULT_ENTRIES :
			((count_reg > MAX_ENTRIES) ? MAX_ENTRIES : count_reg);
		repeat (items) begin
			pick = $urandom_range(99);
			addr = MAP_BASE + $urandom_range(0, 2 * span + 3);
			if (pick < 35)
				push_access(datm_pkg::MODE_WRITE, addr, 1'($urandom_range(1)),
					16'($urandom));
			else if (pick < 65)
				push_access(datm_pkg::MODE_READ, addr, 1'($urandom_range(1)),
					16'($urandom));
			else if (pick < 88)
				push_access(datm_pkg::MODE_TRANSLATE, $urandom, 1'($urandom_range(1)),
					16'($urandom));
			else if (pick < 93)
				push_access(MODE_SPARE, $urandom, 1'($urandom_range(1)), 16'($urandom));
			else if (pick < 97)
				push_access($urandom_range(1) ? datm_pkg::MODE_WRITE : datm_pkg::MODE_READ,
					$urandom_range(MAP_LIMIT - 15, MAP_LIMIT + 16),
					1'($urandom_range(1)), 16'($urandom));
			else
				push_access($urandom_range(1) ? datm_pkg::MODE_WRITE : datm_pkg::MODE_READ,
					$urandom, 1'($urandom_range(1)), 16'($urandom));
		end
	endtask

	// count register settings, one per phase: default, extremes, saturation,
	// counts that are not powers of two
	int unsigned count_plan [PHASES] = '{0, 1, 256, 511, 3, 64, 2, 100, 128};

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part under the reset count. The clearing pass holds s_tready
		// low for a while; push_access just waits it out.
		push_access(datm_pkg::MODE_READ, 32'd0, 1'b0, 16'h0000);
		push_access(datm_pkg::MODE_WRITE, 32'd0, 1'b0, 16'hFFFF);
		push_access(datm_pkg::MODE_READ, 32'd1, 1'b0, 16'h0000);
		push_access(datm_pkg::MODE_TRANSLATE, 32'h0000_0000, 1'b0, 16'h0000);
		push_access(datm_pkg::MODE_TRANSLATE, 32'h0000_03FF, 1'b0, 16'h0000);
		push_access(datm_pkg::MODE_TRANSLATE, 32'h0000_03FF, 1'b1, 16'h0000);
		push_access(datm_pkg::MODE_WRITE, 32'd254, 1'b1, 16'hA5A5);
		push_access(datm_pkg::MODE_TRANSLATE, 32'h0001_FFFF, 1'b1, 16'hFFFF);
		push_access(datm_pkg::MODE_READ, 32'd255, 1'b0, 16'h0000);
		push_access(datm_pkg::MODE_READ, 32'd256, 1'b0, 16'h0000);
		push_access(datm_pkg::MODE_READ, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
		push_access(datm_pkg::MODE_WRITE, 32'd126, 1'b0, 16'h8001);
		push_access(datm_pkg::MODE_TRANSLATE, 32'hFFFF_FFFF, 1'b0, 16'h0000);
		push_access(datm_pkg::MODE_TRANSLATE, 32'hFFFF_FFFF, 1'b1, 16'h0000);
		push_access(datm_pkg::MODE_TRANSLATE, 32'h0000_FFFF, 1'b1, 16'h0000);
		push_access(datm_pkg::MODE_WRITE, 32'd128, 1'b0, 16'h7FFE);
		push_access(datm_pkg::MODE_TRANSLATE, 32'h0001_0000, 1'b1, 16'h0000);
		push_access(datm_pkg::MODE_TRANSLATE, 32'h0001_0000, 1'b0, 16'h0000);
		push_access(datm_pkg::MODE_WRITE, 32'd256, 1'b0, 16'h0000);
		push_access(datm_pkg::MODE_READ, 32'd0, 1'b0, 16'h0000);
		push_access(MODE_SPARE, 32'd0, 1'b1, 16'hFFFF);
		push_access(MODE_SPARE, 32'hFFFF_FFFF, 1'b0, 16'h0000);
		push_access(datm_pkg::MODE_WRITE, 32'hFFFF_FFFE, 1'b1, 16'h1234);
		push_access(datm_pkg::MODE_READ, 32'd254, 1'b0, 16'h0000);

		// Random phases, each under its own count setting. Change the register
		// only once the block has gone idle. Run one phase without any idling
		// and force long receiver stalls in two others.
		for (int p = 0; p < PHASES; p++) begin
			drain();
			write_count(datm_pkg::COUNT_W'(count_plan[p]));
			idle_enabled = (p != 2);
			if (p == 4 || p == 7)
				backpressure_req++;
			random_phase(PHASE_ITEMS, count_plan[p]);
		end

		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
